// ===== sv/bcp_pkg.sv =====
// Shared types and constants of the breath cycle profile calculator.
package bcp_pkg;

	// Shared divider sizes
	localparam int DIV_NUM_W = 32;
	localparam int DIV_DEN_W = 16;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	// Configuration register indexes
	localparam logic [2:0] REG_BPM   = 3'd0;
	localparam logic [2:0] REG_IE    = 3'd1;
	localparam logic [2:0] REG_TIDAL = 3'd2;
	localparam logic [2:0] REG_HOME  = 3'd3;
	localparam logic [2:0] REG_MAX   = 3'd4;

	// Configuration reset values
	localparam logic [5:0]  BPM_RST   = 6'd15;
	localparam logic [2:0]  IE_RST    = 3'd1;
	localparam logic [7:0]  TIDAL_RST = 8'd50;
	localparam logic [23:0] HOME_RST  = 24'd0;
	localparam logic [23:0] MAX_RST   = 24'd0;

	// Fixed arithmetic constants
	localparam logic [31:0] MS_PER_MIN  = 32'd60000;
	localparam logic [13:0] UL_PER_UNIT = 14'd10000;  // microlitres per 10 ml
	localparam logic [15:0] UL_PER_STEP = 16'd2000;   // two ml of error per step
	localparam logic [3:0]  STEPS_UNIT  = 4'd10;      // steps per 10 ml unit
	localparam logic [9:0]  MS_PER_SEC  = 10'd1000;
	localparam int          PLAT_STEPS  = 5;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CYC,
		ST_INSP,
		ST_CORR,
		ST_STEPS,
		ST_SCALE,
		ST_IMUL,
		ST_IFREQ,
		ST_PFREQ,
		ST_EMUL,
		ST_EFREQ,
		ST_OUT
	} state_t;

	// Divider request and response
	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

// ===== sv/bcp_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, zero divisor gives zero.
module bcp_div (
	input  logic                clk,
	input  logic                arst_n,
	input  bcp_pkg::div_req_t   req,
	output bcp_pkg::div_rsp_t   rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [bcp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [bcp_pkg::DIV_DEN_W-1:0] rem_q;
	logic [bcp_pkg::DIV_DEN_W-1:0] den_q;
	logic [bcp_pkg::DIV_NUM_W-1:0] quo_q;

	logic [bcp_pkg::DIV_DEN_W:0]   trial_c;
	logic [bcp_pkg::DIV_DEN_W:0]   diff_c;
	logic                          ge_c;

	// Trial subtract of the divisor from the shifted partial remainder
	always_comb begin
		trial_c = {rem_q, quo_q[bcp_pkg::DIV_NUM_W-1]};
		diff_c  = trial_c - {1'b0, den_q};
		ge_c    = (trial_c >= {1'b0, den_q});
	end

	// Control: busy while the quotient bits are formed, done pulses after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == bcp_pkg::DIV_CNT_W'(1));
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= bcp_pkg::DIV_CNT_W'(bcp_pkg::DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - bcp_pkg::DIV_CNT_W'(1);
				if (cnt_q == bcp_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Shift register: numerator bits leave at the top, quotient bits enter below
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quo_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[bcp_pkg::DIV_NUM_W-2:0], ge_c};
			rem_q <= ge_c ? diff_c[bcp_pkg::DIV_DEN_W-1:0] : trial_c[bcp_pkg::DIV_DEN_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = (den_q == '0) ? '0 : quo_q;

endmodule

// ===== sv/breath_cycle_profile_calc.sv =====
// Words are handled one at a time: a new word is taken only in the idle state, after
// the previous result is loaded. The shared bit-serial divider performs up to six
// divisions per word; the correction division is skipped when the measured volume is zero.
// A finished result waits in the output register while the next word is taken.
// Reset (arst_n low, asynchronous) restores the register defaults and clears the kept count.
module breath_cycle_profile_calc #(
	parameter int MICROSTEPS  = 16,
	parameter int EXP_TIME_MS = 750
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration write port
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [23:0]  cfg_wdata,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [23:0]  s_tdata,   // [23:0] measured_volume
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// [15:0] cycle_ms, [31:16] insp_ms, [55:32] step_count, [87:56] ramp_pulses,
	// [119:88] hold_pulses, [151:120] total_pulses, [183:152] insp_freq,
	// [215:184] plateau_freq, [247:216] exp_freq, [248] steps_clamped, rest zero
	output logic [255:0] m_tdata
);

	localparam int          MS_W      = $clog2(MICROSTEPS + 1);
	localparam logic [MS_W-1:0] MS_C  = MS_W'(MICROSTEPS);
	localparam logic [31:0] PLAT_C    = 32'(MICROSTEPS * bcp_pkg::PLAT_STEPS);
	localparam logic [31:0] PFNUM_C   = 32'(MICROSTEPS * bcp_pkg::PLAT_STEPS * 1000);
	localparam logic [15:0] EXP_DEN_C = 16'(EXP_TIME_MS);

	// Configuration registers
	logic [5:0]  bpm_q;
	logic [2:0]  ie_q;
	logic [7:0]  tidal_q;
	logic [23:0] home_q;
	logic [23:0] max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpm_q   <= bcp_pkg::BPM_RST;
			ie_q    <= bcp_pkg::IE_RST;
			tidal_q <= bcp_pkg::TIDAL_RST;
			home_q  <= bcp_pkg::HOME_RST;
			max_q   <= bcp_pkg::MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bcp_pkg::REG_BPM:   bpm_q   <= cfg_wdata[5:0];
				bcp_pkg::REG_IE:    ie_q    <= cfg_wdata[2:0];
				bcp_pkg::REG_TIDAL: tidal_q <= cfg_wdata[7:0];
				bcp_pkg::REG_HOME:  home_q  <= cfg_wdata;
				bcp_pkg::REG_MAX:   max_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	bcp_pkg::state_t   state_q, state_d;
	bcp_pkg::div_req_t div_req;
	bcp_pkg::div_rsp_t div_rsp;
	logic              started_q;

	// Working registers
	logic        meas_zero_q;
	logic        err_neg_q;
	logic [24:0] err_mag_q;
	logic [15:0] cycle_q;
	logic [15:0] insp_q;
	logic [31:0] corr_q;
	logic [31:0] last_q;
	logic        clamped_q;
	logic [31:0] total_q;
	logic [31:0] prod_q;
	logic [31:0] ifreq_q;
	logic [31:0] pfreq_q;
	logic [31:0] efreq_q;

	// Output register
	logic        out_valid_q;
	logic [15:0] o_cycle_q;
	logic [15:0] o_insp_q;
	logic [23:0] o_steps_q;
	logic [31:0] o_inspp_q;
	logic [31:0] o_total_q;
	logic [31:0] o_ifreq_q;
	logic [31:0] o_pfreq_q;
	logic [31:0] o_efreq_q;
	logic        o_clamped_q;

	logic        accept_c;
	logic        out_load_c;
	logic        div_state_c;
	logic [21:0] tv_scaled_c;
	logic [25:0] err_c;
	logic [25:0] err_abs_c;
	logic [31:0] span_c;
	logic [31:0] steps_c;
	logic [31:0] inspp_c;
	logic [15:0] tplat_c;
	logic [15:0] tinsp_c;
	logic [5:0]  bpm_c;

	// Volume error against target, magnitude and sign, formed at accept
	always_comb begin
		tv_scaled_c = 22'(tidal_q) * 22'(bcp_pkg::UL_PER_UNIT);
		err_c       = {4'b0, tv_scaled_c} - {{2{s_tdata[23]}}, s_tdata};
		err_abs_c   = err_c[25] ? (26'd0 - err_c) : err_c;
	end

	// Span, step count before the span clamp, ramp pulses, phase times
	always_comb begin
		span_c  = {8'b0, max_q} - {8'b0, home_q};
		steps_c = meas_zero_q ? {20'b0, 12'(tidal_q * bcp_pkg::STEPS_UNIT)} : last_q + corr_q;
		inspp_c = total_q - PLAT_C;
		tplat_c = {2'b0, insp_q[15:2]};
		tinsp_c = insp_q - tplat_c;
		bpm_c   = (bpm_q == 6'd0) ? 6'd1 : bpm_q;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bcp_pkg::ST_IDLE:  if (s_tvalid) state_d = bcp_pkg::ST_CYC;
			bcp_pkg::ST_CYC:   if (div_rsp.done) state_d = bcp_pkg::ST_INSP;
			bcp_pkg::ST_INSP:  if (div_rsp.done) state_d = bcp_pkg::ST_CORR;
			bcp_pkg::ST_CORR:  if (meas_zero_q || div_rsp.done) state_d = bcp_pkg::ST_STEPS;
			bcp_pkg::ST_STEPS: state_d = bcp_pkg::ST_SCALE;
			bcp_pkg::ST_SCALE: state_d = bcp_pkg::ST_IMUL;
			bcp_pkg::ST_IMUL:  state_d = bcp_pkg::ST_IFREQ;
			bcp_pkg::ST_IFREQ: if (div_rsp.done) state_d = bcp_pkg::ST_PFREQ;
			bcp_pkg::ST_PFREQ: if (div_rsp.done) state_d = bcp_pkg::ST_EMUL;
			bcp_pkg::ST_EMUL:  state_d = bcp_pkg::ST_EFREQ;
			bcp_pkg::ST_EFREQ: if (div_rsp.done) state_d = bcp_pkg::ST_OUT;
			bcp_pkg::ST_OUT:   if (!out_valid_q || m_tready) state_d = bcp_pkg::ST_IDLE;
			default:           state_d = bcp_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake and divider operand select
	always_comb begin
		s_tready    = 1'b0;
		div_state_c = 1'b0;
		div_req.num = '0;
		div_req.den = '0;
		case (state_q)
			bcp_pkg::ST_IDLE: s_tready = 1'b1;
			bcp_pkg::ST_CYC: begin
				div_state_c = 1'b1;
				div_req.num = bcp_pkg::MS_PER_MIN;
				div_req.den = {10'b0, bpm_c};
			end
			bcp_pkg::ST_INSP: begin
				div_state_c = 1'b1;
				div_req.num = {16'b0, cycle_q};
				div_req.den = {12'b0, {1'b0, ie_q} + 4'd1};
			end
			bcp_pkg::ST_CORR: begin
				div_state_c = !meas_zero_q;
				div_req.num = {7'b0, err_mag_q};
				div_req.den = bcp_pkg::UL_PER_STEP;
			end
			bcp_pkg::ST_IFREQ: begin
				div_state_c = 1'b1;
				div_req.num = prod_q;
				div_req.den = tinsp_c;
			end
			bcp_pkg::ST_PFREQ: begin
				div_state_c = 1'b1;
				div_req.num = PFNUM_C;
				div_req.den = tplat_c;
			end
			bcp_pkg::ST_EFREQ: begin
				div_state_c = 1'b1;
				div_req.num = prod_q;
				div_req.den = EXP_DEN_C;
			end
			default: ;
		endcase
		div_req.start = div_state_c && !started_q;
	end

	assign accept_c   = s_tvalid && s_tready;
	assign out_load_c = (state_q == bcp_pkg::ST_OUT) && (!out_valid_q || m_tready);

	bcp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bcp_pkg::ST_IDLE;
			started_q   <= 1'b0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (div_rsp.done) begin
				started_q <= 1'b0;
			end else if (div_req.start) begin
				started_q <= 1'b1;
			end
			if (state_q == bcp_pkg::ST_STEPS) begin
				last_q <= (steps_c > span_c) ? span_c : steps_c;
			end
			if (out_load_c) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath capture
	always_ff @(posedge clk) begin
		if (accept_c) begin
			meas_zero_q <= (s_tdata == 24'd0);
			err_neg_q   <= err_c[25];
			err_mag_q   <= err_abs_c[24:0];
		end
		if (div_rsp.done) begin
			case (state_q)
				bcp_pkg::ST_CYC:   cycle_q <= div_rsp.quo[15:0];
				bcp_pkg::ST_INSP:  insp_q  <= div_rsp.quo[15:0];
				bcp_pkg::ST_CORR:  corr_q  <= err_neg_q ? (32'd0 - div_rsp.quo) : div_rsp.quo;
				bcp_pkg::ST_IFREQ: ifreq_q <= div_rsp.quo;
				bcp_pkg::ST_PFREQ: pfreq_q <= div_rsp.quo;
				bcp_pkg::ST_EFREQ: efreq_q <= div_rsp.quo;
				default: ;
			endcase
		end
		if (state_q == bcp_pkg::ST_STEPS) begin
			clamped_q <= (steps_c > span_c);
		end
		if (state_q == bcp_pkg::ST_SCALE) begin
			total_q <= 32'(last_q * MS_C);
		end
		if (state_q == bcp_pkg::ST_IMUL) begin
			prod_q <= 32'(inspp_c * bcp_pkg::MS_PER_SEC);
		end
		if (state_q == bcp_pkg::ST_EMUL) begin
			prod_q <= 32'(total_q * bcp_pkg::MS_PER_SEC);
		end
		if (out_load_c) begin
			o_cycle_q   <= cycle_q;
			o_insp_q    <= insp_q;
			o_steps_q   <= last_q[23:0];
			o_inspp_q   <= inspp_c;
			o_total_q   <= total_q;
			o_ifreq_q   <= ifreq_q;
			o_pfreq_q   <= pfreq_q;
			o_efreq_q   <= efreq_q;
			o_clamped_q <= clamped_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, o_clamped_q, o_efreq_q, o_pfreq_q, o_ifreq_q, o_total_q,
		PLAT_C, o_inspp_q, o_steps_q, o_insp_q, o_cycle_q};

`ifndef SYNTH
	// A division is launched only into an idle divider
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// A finished division always belongs to a launched one
	a_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> started_q)
		else $error("divider done without a pending launch");

	// An accepted word starts the cycle time division
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		accept_c |=> (state_q == bcp_pkg::ST_CYC) && div_req.start)
		else $error("accepted word did not start the sequence");

	// A clamped count equals the position span
	a_clamp_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bcp_pkg::ST_SCALE) && clamped_q |-> (last_q == span_c))
		else $error("clamped step count differs from span");
`endif

endmodule
